>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the LED current regulator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/lcr_pkg.sv
// Types, constants and functions of the LED current regulator.
// Used by lcr_ctrl, lcr_datapath and led_current_regulator_core.
package lcr_pkg;

   localparam int LEVELS = 8;

   localparam int DIV_SHIFT = 28;
   localparam logic [18:0] RECIP_1000 = 19'd268436;
   localparam logic [17:0] DIV_1000 = 18'd1000;

   typedef enum logic [1:0] {
      FUNC_SAMPLE  = 2'd0,
      FUNC_CLICK   = 2'd1,
      FUNC_BATTERY = 2'd2,
      FUNC_HOLD    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_WARN_LEVEL    = 3'd0,
      CSR_CUTOFF_LEVEL  = 3'd1,
      CSR_CHARGE_HIGH   = 3'd2,
      CSR_CHARGE_MID    = 3'd3,
      CSR_CHARGE_LOW    = 3'd4,
      CSR_MAX_DUTY      = 3'd5,
      CSR_INTEGRAL_GAIN = 3'd6,
      CSR_CURRENT_SCALE = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_SUM,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic pre;
      logic sum;
      logic mul;
      logic div;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic loop_req;
   } status_type;

   function automatic logic [8:0] setpoint(input logic [2:0] idx);
      logic [8:0] sp;
      case (idx)
         3'd0: sp = 9'd0;
         3'd1: sp = 9'd5;
         3'd2: sp = 9'd10;
         3'd3: sp = 9'd25;
         3'd4: sp = 9'd50;
         3'd5: sp = 9'd100;
         3'd6: sp = 9'd200;
         3'd7: sp = 9'd300;
         default: sp = 9'd0;
      endcase
      return sp;
   endfunction

endpackage

>>> hdl/lcr_ctrl.sv
// Sequencer of the LED current regulator: steps one item through the datapath.
// Depends on lcr_pkg for state, command and status types.
module lcr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  lcr_pkg::status_type status,
   output lcr_pkg::cmd_type    cmd
);

   lcr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lcr_pkg::ST_PRE;
         end
         lcr_pkg::ST_PRE: begin
            state_in = status.loop_req ? lcr_pkg::ST_SUM : lcr_pkg::ST_FIN;
         end
         lcr_pkg::ST_SUM: state_in = lcr_pkg::ST_MUL;
         lcr_pkg::ST_MUL: state_in = lcr_pkg::ST_DIV;
         lcr_pkg::ST_DIV: state_in = lcr_pkg::ST_FIN;
         lcr_pkg::ST_FIN: begin
            if (out_free) state_in = lcr_pkg::ST_IDLE;
         end
         default: state_in = lcr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         lcr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         lcr_pkg::ST_PRE: cmd.pre = 1'b1;
         lcr_pkg::ST_SUM: cmd.sum = 1'b1;
         lcr_pkg::ST_MUL: cmd.mul = 1'b1;
         lcr_pkg::ST_DIV: cmd.div = 1'b1;
         lcr_pkg::ST_FIN: begin
            if (out_free) begin
               cmd.fin = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/lcr_datapath.sv
// Datapath of the LED current regulator: settings, regulator state, integral
// loop arithmetic and the result register. Depends on lcr_pkg.
module lcr_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [9:0]         csr_wdata,
   input  logic [1:0]         req_tuser,
   input  logic [23:0]        req_tdata,
   output logic [15:0]        rsp_tdata,
   input  lcr_pkg::cmd_type    cmd,
   output lcr_pkg::status_type status
);

   // settings
   logic [9:0] warn_level_ff, cutoff_level_ff, charge_high_ff, charge_mid_ff, charge_low_ff;
   logic [7:0] max_duty_ff, integral_gain_ff, current_scale_ff;

   // regulator state
   logic [2:0]  level_ff, level_in;
   logic [15:0] integ_ff, integ_in;
   logic [7:0]  duty_ff, duty_in;
   logic        warned_ff, warned_in;
   logic [9:0]  last_bat_ff, last_bat_in;

   // item and loop work registers
   logic [1:0]  func_ff;
   logic [13:0] cur_ff;
   logic [9:0]  bat_ff;
   logic        warn_flag_ff, warn_flag_in;
   logic        fault_in;
   logic [16:0] target_ff;
   logic        run_ff;
   logic [15:0] isum_ff;
   logic [23:0] prod_ff;
   logic [17:0] limit_ff;
   logic        over_ff;
   logic [7:0]  quo_ff;
   logic [15:0] rsp_data_ff;

   logic [3:0]  level_up;
   logic [16:0] err;
   logic [17:0] sum_wide;
   logic [36:0] recip_prod;
   logic [2:0]  flashes;
   lcr_pkg::func_type func;

   assign func = lcr_pkg::func_type'(func_ff);
   assign status.loop_req = (func == lcr_pkg::FUNC_SAMPLE) || (func == lcr_pkg::FUNC_BATTERY);
   assign level_up = {1'b0, level_ff} + 4'd1;
   assign err = target_ff - {3'b000, cur_ff};
   assign sum_wide = {2'b00, integ_ff} + {1'b0, err};
   assign recip_prod = {19'd0, prod_ff[17:0]} * {18'd0, lcr_pkg::RECIP_1000};

   always_comb begin
      level_in = level_ff;
      integ_in = integ_ff;
      duty_in = duty_ff;
      warned_in = warned_ff;
      last_bat_in = last_bat_ff;
      warn_flag_in = warn_flag_ff;
      fault_in = 1'b0;
      if (cmd.pre) begin
         warn_flag_in = 1'b0;
         case (func)
            lcr_pkg::FUNC_SAMPLE: begin
               level_in = level_ff;
            end
            lcr_pkg::FUNC_CLICK: begin
               if (({1'b0, level_up} >= 5'(lcr_pkg::LEVELS)) || (level_up > 4'd7)) begin
                  level_in = 3'd0;
                  integ_in = 16'd0;
                  duty_in = 8'd0;
                  warned_in = 1'b0;
               end else begin
                  level_in = level_up[2:0];
               end
            end
            lcr_pkg::FUNC_BATTERY: begin
               last_bat_in = bat_ff;
               if (bat_ff >= warn_level_ff && bat_ff < cutoff_level_ff && !warned_ff &&
                   level_ff != 3'd0) begin
                  warned_in = 1'b1;
                  warn_flag_in = 1'b1;
               end else if (bat_ff >= cutoff_level_ff && level_ff != 3'd0) begin
                  level_in = 3'd0;
                  integ_in = 16'd0;
                  duty_in = 8'd0;
                  warned_in = 1'b0;
               end
            end
            lcr_pkg::FUNC_HOLD: begin
               level_in = 3'd0;
               integ_in = 16'd0;
               duty_in = 8'd0;
               warned_in = 1'b0;
               last_bat_in = 10'd0;
            end
            default: level_in = level_ff;
         endcase
      end else if (cmd.fin && run_ff) begin
         if (over_ff) begin
            level_in = 3'd0;
            integ_in = 16'd0;
            duty_in = 8'd0;
            warned_in = 1'b0;
            fault_in = 1'b1;
         end else begin
            integ_in = isum_ff;
            duty_in = quo_ff;
         end
      end
   end

   always_comb begin
      if (last_bat_ff < charge_high_ff) flashes = 3'd4;
      else if (last_bat_ff < charge_mid_ff) flashes = 3'd3;
      else if (last_bat_ff < charge_low_ff) flashes = 3'd2;
      else flashes = 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_level_ff <= 10'd320;
         cutoff_level_ff <= 10'd360;
         charge_high_ff <= 10'd288;
         charge_mid_ff <= 10'd300;
         charge_low_ff <= 10'd305;
         max_duty_ff <= 8'd194;
         integral_gain_ff <= 8'd5;
         current_scale_ff <= 8'd29;
      end else if (csr_we) begin
         case (lcr_pkg::csr_index_type'(csr_index))
            lcr_pkg::CSR_WARN_LEVEL:    warn_level_ff <= csr_wdata;
            lcr_pkg::CSR_CUTOFF_LEVEL:  cutoff_level_ff <= csr_wdata;
            lcr_pkg::CSR_CHARGE_HIGH:   charge_high_ff <= csr_wdata;
            lcr_pkg::CSR_CHARGE_MID:    charge_mid_ff <= csr_wdata;
            lcr_pkg::CSR_CHARGE_LOW:    charge_low_ff <= csr_wdata;
            lcr_pkg::CSR_MAX_DUTY:      max_duty_ff <= csr_wdata[7:0];
            lcr_pkg::CSR_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata[7:0];
            lcr_pkg::CSR_CURRENT_SCALE: current_scale_ff <= csr_wdata[7:0];
            default: warn_level_ff <= warn_level_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 3'd0;
         integ_ff <= 16'd0;
         duty_ff <= 8'd0;
         warned_ff <= 1'b0;
         last_bat_ff <= 10'd0;
         warn_flag_ff <= 1'b0;
         run_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         integ_ff <= integ_in;
         duty_ff <= duty_in;
         warned_ff <= warned_in;
         last_bat_ff <= last_bat_in;
         warn_flag_ff <= warn_flag_in;
         if (cmd.pre) begin
            run_ff <= 1'b0;
         end else if (cmd.sum) begin
            run_ff <= target_ff > {3'b000, cur_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         cur_ff <= req_tdata[13:0];
         bat_ff <= req_tdata[23:14];
      end
      if (cmd.pre) begin
         target_ff <= {9'd0, current_scale_ff} * {8'd0, lcr_pkg::setpoint(level_in)};
      end
      if (cmd.sum) begin
         isum_ff <= (sum_wide[17:16] != 2'b00) ? 16'hFFFF : sum_wide[15:0];
      end
      if (cmd.mul) begin
         prod_ff <= {16'd0, integral_gain_ff} * {8'd0, isum_ff};
         limit_ff <= ({9'd0, max_duty_ff} + 18'd1) * lcr_pkg::DIV_1000;
      end
      if (cmd.div) begin
         over_ff <= prod_ff >= {6'd0, limit_ff};
         quo_ff <= recip_prod[lcr_pkg::DIV_SHIFT +: 8];
      end
      if (cmd.fin) begin
         rsp_data_ff <= {flashes, level_in, warn_flag_ff, fault_in, duty_in};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

>>> hdl/led_current_regulator_core.sv
// LED current regulator: one item per command, one result item each.
// Click and hold items step through accept, update and result; current and battery
// items through accept, update, integrator add, gain multiply, divide by 1000, result.
// A new item is accepted only once the result of the last has been registered; the
// result step waits while the previous result is still not taken. Reset (synchronous,
// active high) loads register defaults, clears the regulator state and rsp_tvalid, and idles the sequencer.
`include "assert_macros.svh"

module led_current_regulator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // current_sample[13:0], battery_sample[23:14]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // duty[7:0], fault[8], warn_pulse[9], level[12:10],
                                    // flash_count[15:13]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   lcr_pkg::cmd_type    cmd;
   lcr_pkg::status_type status;

   lcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

   `ASSERT_PROP(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "accepted a second item while busy")
   `ASSERT_NEVER(a_off_with_duty, clock, reset, rsp_tvalid && rsp_tdata[12:10] == 3'd0 && rsp_tdata[7:0] != 8'd0, "nonzero duty at level off")
   `ASSERT_NEVER(a_fault_not_off, clock, reset, rsp_tvalid && rsp_tdata[8] && (rsp_tdata[12:10] != 3'd0 || rsp_tdata[7:0] != 8'd0), "fault without shutdown")
   `ASSERT_NEVER(a_warn_when_off, clock, reset, rsp_tvalid && rsp_tdata[9] && !rsp_tdata[8] && rsp_tdata[12:10] == 3'd0, "warning raised while off")

endmodule

>>> bench/led_current_regulator_checker.sv
// Checker for led_current_regulator_core: watches the req, rsp and csr ports,
// predicts every result item and compares it field by field.
// Depends on lcr_pkg for the func and register index codes.
`timescale 1ns / 100ps

module led_current_regulator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // current_sample[13:0], battery_sample[23:14]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // duty[7:0], fault[8], warn_pulse[9], level[12:10],
                                    // flash_count[15:13]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata,
   output int          outstanding,
   output int          mismatches
);

   typedef struct packed {
      logic [2:0] flash_count;
      logic [2:0] level;
      logic       warn_pulse;
      logic       fault;
      logic [7:0] duty;
   } lcr_status_type;

   logic [9:0] warn_r, cutoff_r, chg_high_r, chg_mid_r, chg_low_r;
   logic [7:0] duty_max_r, gain_r, scale_r;

   logic [2:0]  level_r;
   logic [15:0] integ_r;
   logic [7:0]  duty_r;
   logic        warned_r;
   logic [9:0]  battery_r;

   lcr_status_type status_q[$];
   lcr_status_type got, want;
   int             mismatch_count = 0;

   assign mismatches = mismatch_count;

   task automatic report_mismatch(input string field, input int seen, input int wanted);
      if (mismatch_count < 50)
         $display("%0t: %s mismatch, got %0d expected %0d", $time, field, seen, wanted);
      mismatch_count++;
   endtask

   function automatic int unsigned level_setpoint(input logic [2:0] idx);
      case (idx)
         3'd1: return 5;
         3'd2: return 10;
         3'd3: return 25;
         3'd4: return 50;
         3'd5: return 100;
         3'd6: return 200;
         3'd7: return 300;
         default: return 0;
      endcase
   endfunction

   function automatic logic [2:0] flashes_for(input logic [9:0] bat);
      if (bat < chg_high_r) return 3'd4;
      if (bat < chg_mid_r) return 3'd3;
      if (bat < chg_low_r) return 3'd2;
      return 3'd1;
   endfunction

   task automatic clear_loop();
      level_r = 3'd0;
      integ_r = 16'd0;
      duty_r = 8'd0;
      warned_r = 1'b0;
   endtask

   task automatic run_integrator(input logic [13:0] cur, output logic tripped);
      int unsigned target, acc, cmd;
      tripped = 1'b0;
      target = int'(scale_r) * level_setpoint(level_r);
      if (target > cur) begin
         acc = integ_r + target - cur;
         if (acc > 65535)
            acc = 65535;
         integ_r = acc[15:0];
         cmd = int'(gain_r) * acc / 1000;
         if (cmd > duty_max_r) begin
            clear_loop();
            tripped = 1'b1;
         end else begin
            duty_r = cmd[7:0];
         end
      end
   endtask

   task automatic step_regulator(input lcr_pkg::func_type func, input logic [13:0] cur,
                                 input logic [9:0] bat, output lcr_status_type res);
      logic tripped, warned_now;
      tripped = 1'b0;
      warned_now = 1'b0;
      case (func)
         lcr_pkg::FUNC_SAMPLE: run_integrator(cur, tripped);
         lcr_pkg::FUNC_CLICK: begin
            if (int'(level_r) + 1 >= lcr_pkg::LEVELS)
               clear_loop();
            else
               level_r = level_r + 3'd1;
         end
         lcr_pkg::FUNC_BATTERY: begin
            battery_r = bat;
            if (bat >= warn_r && bat < cutoff_r && !warned_r && level_r != 3'd0) begin
               warned_r = 1'b1;
               warned_now = 1'b1;
            end else if (bat >= cutoff_r && level_r != 3'd0) begin
               clear_loop();
            end
            run_integrator(cur, tripped);
         end
         lcr_pkg::FUNC_HOLD: begin
            clear_loop();
            battery_r = 10'd0;
         end
         default: tripped = 1'b0;
      endcase
      res.duty = duty_r;
      res.fault = tripped;
      res.warn_pulse = warned_now;
      res.level = level_r;
      res.flash_count = flashes_for(battery_r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         warn_r = 10'd320;
         cutoff_r = 10'd360;
         chg_high_r = 10'd288;
         chg_mid_r = 10'd300;
         chg_low_r = 10'd305;
         duty_max_r = 8'd194;
         gain_r = 8'd5;
         scale_r = 8'd29;
         clear_loop();
         battery_r = 10'd0;
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (status_q.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_tdata, 0);
            end else begin
               want = status_q.pop_front();
               if (got.duty != want.duty)
                  report_mismatch("duty", got.duty, want.duty);
               if (got.fault != want.fault)
                  report_mismatch("fault", got.fault, want.fault);
               if (got.warn_pulse != want.warn_pulse)
                  report_mismatch("warn_pulse", got.warn_pulse, want.warn_pulse);
               if (got.level != want.level)
                  report_mismatch("level", got.level, want.level);
               if (got.flash_count != want.flash_count)
                  report_mismatch("flash_count", got.flash_count, want.flash_count);
            end
         end
         if (csr_we) begin
            case (lcr_pkg::csr_index_type'(csr_index))
               lcr_pkg::CSR_WARN_LEVEL:    warn_r = csr_wdata;
               lcr_pkg::CSR_CUTOFF_LEVEL:  cutoff_r = csr_wdata;
               lcr_pkg::CSR_CHARGE_HIGH:   chg_high_r = csr_wdata;
               lcr_pkg::CSR_CHARGE_MID:    chg_mid_r = csr_wdata;
               lcr_pkg::CSR_CHARGE_LOW:    chg_low_r = csr_wdata;
               lcr_pkg::CSR_MAX_DUTY:      duty_max_r = csr_wdata[7:0];
               lcr_pkg::CSR_INTEGRAL_GAIN: gain_r = csr_wdata[7:0];
               lcr_pkg::CSR_CURRENT_SCALE: scale_r = csr_wdata[7:0];
               default: warn_r = warn_r;
            endcase
         end
         if (req_tvalid && req_tready) begin
            step_regulator(lcr_pkg::func_type'(req_tuser), req_tdata[13:0], req_tdata[23:14],
                           want);
            status_q.push_back(want);
         end
      end
      outstanding <= status_q.size();
   end

endmodule

>>> bench/tb_led_current_regulator_core.sv
// Testbench top for led_current_regulator_core: clock, reset, register phases,
// directed and random items with random gaps and result stalls, and the verdict.
// Depends on lcr_pkg and led_current_regulator_checker.
`timescale 1ns / 100ps

module tb_led_current_regulator_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // current_sample[13:0], battery_sample[23:14]
   logic [1:0]  req_tuser = lcr_pkg::FUNC_SAMPLE;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // duty[7:0], fault[8], warn_pulse[9], level[12:10],
                             // flash_count[15:13]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = lcr_pkg::CSR_WARN_LEVEL;
   logic [9:0]  csr_wdata = '0;

   int         outstanding;
   int         mismatches;
   logic [9:0] cfg [8];
   bit         no_gaps = 1'b0;
   int         stall_left = 0;
   int         quiet_left = 0;
   int         stall_roll;

   always #2 clock = ~clock;

   led_current_regulator_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   led_current_regulator_checker u_monitor (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .outstanding(outstanding),
      .mismatches(mismatches)
   );

   always @(posedge clock) begin
      if (quiet_left > 0) begin
         quiet_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 3)
            quiet_left = $urandom_range(20, 200);
         else if (stall_roll < 6)
            stall_left = $urandom_range(10, 60);
         else if (stall_roll < 35)
            stall_left = $urandom_range(0, 3);
         rsp_tready <= (stall_roll >= 35 || stall_roll < 3);
      end
   end

   task automatic send_item(input lcr_pkg::func_type func, input int cur, input int bat);
      int         gap, roll;
      logic [13:0] cur_bits;
      logic [9:0]  bat_bits;
      cur_bits = cur[13:0];
      bat_bits = bat[9:0];
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 50)
         gap = 0;
      else if (roll < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bat_bits, cur_bits};
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random();
      int                roll, span, cur, bat;
      lcr_pkg::func_type func;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         func = lcr_pkg::FUNC_SAMPLE;
      else if (roll < 67)
         func = lcr_pkg::FUNC_CLICK;
      else if (roll < 95)
         func = lcr_pkg::FUNC_BATTERY;
      else
         func = lcr_pkg::FUNC_HOLD;
      span = int'(cfg[lcr_pkg::CSR_CURRENT_SCALE][7:0]) * 300;
      if (span > 16383)
         span = 16383;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         cur = $urandom_range(0, 16383);
      else if (roll < 75)
         cur = $urandom_range(0, span);
      else
         cur = $urandom_range(0, span / 12);
      if ($urandom_range(0, 99) < 40) begin
         bat = int'(cfg[$urandom_range(0, 4)]) + int'($urandom_range(0, 6)) - 3;
         if (bat < 0)
            bat = 0;
         if (bat > 1023)
            bat = 1023;
      end else begin
         bat = $urandom_range(0, 1023);
      end
      send_item(func, cur, bat);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         send_random();
      end
   endtask

   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input lcr_pkg::csr_index_type idx, input logic [9:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_registers(input int warn, input int cutoff, input int hi, input int mid,
                                input int lo, input int dmax, input int gain, input int scale);
      cfg[lcr_pkg::CSR_WARN_LEVEL] = warn[9:0];
      cfg[lcr_pkg::CSR_CUTOFF_LEVEL] = cutoff[9:0];
      cfg[lcr_pkg::CSR_CHARGE_HIGH] = hi[9:0];
      cfg[lcr_pkg::CSR_CHARGE_MID] = mid[9:0];
      cfg[lcr_pkg::CSR_CHARGE_LOW] = lo[9:0];
      cfg[lcr_pkg::CSR_MAX_DUTY] = dmax[9:0];
      cfg[lcr_pkg::CSR_INTEGRAL_GAIN] = gain[9:0];
      cfg[lcr_pkg::CSR_CURRENT_SCALE] = scale[9:0];
      write_csr(lcr_pkg::CSR_WARN_LEVEL, cfg[lcr_pkg::CSR_WARN_LEVEL]);
      write_csr(lcr_pkg::CSR_CUTOFF_LEVEL, cfg[lcr_pkg::CSR_CUTOFF_LEVEL]);
      write_csr(lcr_pkg::CSR_CHARGE_HIGH, cfg[lcr_pkg::CSR_CHARGE_HIGH]);
      write_csr(lcr_pkg::CSR_CHARGE_MID, cfg[lcr_pkg::CSR_CHARGE_MID]);
      write_csr(lcr_pkg::CSR_CHARGE_LOW, cfg[lcr_pkg::CSR_CHARGE_LOW]);
      write_csr(lcr_pkg::CSR_MAX_DUTY, cfg[lcr_pkg::CSR_MAX_DUTY]);
      write_csr(lcr_pkg::CSR_INTEGRAL_GAIN, cfg[lcr_pkg::CSR_INTEGRAL_GAIN]);
      write_csr(lcr_pkg::CSR_CURRENT_SCALE, cfg[lcr_pkg::CSR_CURRENT_SCALE]);
      csr_we <= 1'b0;
   endtask

   task automatic randomize_registers();
      if ($urandom_range(0, 1) == 0)
         set_registers($urandom_range(200, 400), $urandom_range(200, 450),
                       $urandom_range(250, 350), $urandom_range(250, 350),
                       $urandom_range(250, 350), $urandom_range(60, 255),
                       $urandom_range(1, 20), $urandom_range(5, 60));
      else
         set_registers($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   initial begin
      cfg[lcr_pkg::CSR_WARN_LEVEL] = 10'd320;
      cfg[lcr_pkg::CSR_CUTOFF_LEVEL] = 10'd360;
      cfg[lcr_pkg::CSR_CHARGE_HIGH] = 10'd288;
      cfg[lcr_pkg::CSR_CHARGE_MID] = 10'd300;
      cfg[lcr_pkg::CSR_CHARGE_LOW] = 10'd305;
      cfg[lcr_pkg::CSR_MAX_DUTY] = 10'd194;
      cfg[lcr_pkg::CSR_INTEGRAL_GAIN] = 10'd5;
      cfg[lcr_pkg::CSR_CURRENT_SCALE] = 10'd29;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(lcr_pkg::FUNC_HOLD, 0, 0);
      send_item(lcr_pkg::FUNC_BATTERY, 16383, 0);
      send_item(lcr_pkg::FUNC_CLICK, 0, 0);
      send_item(lcr_pkg::FUNC_SAMPLE, 0, 0);
      send_item(lcr_pkg::FUNC_SAMPLE, 16383, 1023);
      send_item(lcr_pkg::FUNC_BATTERY, 100, 320);
      repeat (6) send_item(lcr_pkg::FUNC_CLICK, 0, 0);
      repeat (5) send_item(lcr_pkg::FUNC_SAMPLE, 0, 0);
      send_item(lcr_pkg::FUNC_CLICK, 0, 0);
      send_item(lcr_pkg::FUNC_BATTERY, 16383, 340);
      send_item(lcr_pkg::FUNC_BATTERY, 16383, 330);
      send_item(lcr_pkg::FUNC_BATTERY, 16383, 360);
      send_item(lcr_pkg::FUNC_BATTERY, 0, 287);
      send_item(lcr_pkg::FUNC_BATTERY, 0, 299);
      send_item(lcr_pkg::FUNC_BATTERY, 0, 304);
      send_item(lcr_pkg::FUNC_BATTERY, 16383, 1023);
      send_item(lcr_pkg::FUNC_HOLD, 16383, 1023);
      run_random(300);

      settle(8);
      set_registers(0, 1023, 0, 0, 0, 0, 0, 255);
      run_random(120);
      settle(8);
      set_registers(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
      run_random(120);
      settle(8);
      set_registers(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(80);
      repeat (4) begin
         settle(8);
         randomize_registers();
         run_random(160);
      end

      settle(20);
      if (mismatches == 0)
         $display("tb_led_current_regulator_core OK");
      else
         $display("tb_led_current_regulator_core NOT OK");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_led_current_regulator_core NOT OK");
      $finish;
   end

endmodule
